/* rtl/ffsa_pkg.sv */
// Shared constants, header word layout and memory request type of the scratch allocator.
package ffsa_pkg;

	localparam int unsigned POOL_BYTES  = 65536;
	localparam int unsigned HDR_BYTES   = 4;
	localparam int unsigned STORE_DEPTH = POOL_BYTES / 4;
	localparam int unsigned POOL_END    = STORE_DEPTH * 4;
	localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
	localparam int unsigned POS_W       = IDX_W + 2;
	localparam int unsigned SIZE_W      = 31;
	localparam int unsigned ASIZE_W     = 17;
	localparam int unsigned REQ_W       = ASIZE_W + 1;
	localparam int unsigned OFFS_W      = 16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_NO_SPACE  = 2'd1,
		ST_FREED     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic              is_free;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	// whole pool as one free block
	localparam hdr_t HDR_RESET = '{is_free: 1'b1, size: SIZE_W'(POOL_END - HDR_BYTES)};

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_idx;
		logic wr_en;
		idx_t wr_idx;
		hdr_t wr_data;
	} mem_req_t;

endpackage

/* rtl/ffsa_req_if.sv */
// Request channel: operation, allocate size and offset to free.
interface ffsa_req_if;
	import ffsa_pkg::*;

	logic               valid;
	logic               ready;
	logic               op;
	logic [ASIZE_W-1:0] alloc_size;
	logic [OFFS_W-1:0]  free_offset;

	modport source (output valid, output op, output alloc_size, output free_offset, input ready);
	modport sink (input valid, input op, input alloc_size, input free_offset, output ready);
endinterface

/* rtl/ffsa_rsp_if.sv */
// Response channel: status and allocated payload offset.
interface ffsa_rsp_if;
	import ffsa_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [OFFS_W-1:0] payload_offset;

	modport source (output valid, output status, output payload_offset, input ready);
	modport sink (input valid, input status, input payload_offset, output ready);
endinterface

/* rtl/first_fit_scratch_allocator.sv */
// Top level of the first-fit scratch allocator: chain walker and header store.
// A request visits headers one per cycle as the header store returns each read. A miss goes
// to the result state; a free passes the merge or free write; an allocation passes the used
// write, after the split write if it splits. A new request is accepted once the result beat
// enters the output register, which must first be empty or have its beat taken.
// After reset the walker is idle and word 0 reads as one free block spanning the pool;
// no clearing pass runs, requests are accepted from the first cycle.
module first_fit_scratch_allocator (
	input  logic       clk,
	input  logic       arst_n,
	ffsa_req_if.sink   req,
	ffsa_rsp_if.source rsp
);
	import ffsa_pkg::*;

	mem_req_t mem_req;
	hdr_t     rd_data;

	ffsa_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	ffsa_hdr_mem u_hdr_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (rd_data)
	);
endmodule

/* rtl/ffsa_hdr_mem.sv */
// Header store: one-port-write, one-port-read synchronous memory with word 0 reset flag.
module ffsa_hdr_mem (
	input  logic               clk,
	input  logic               arst_n,
	input  ffsa_pkg::mem_req_t req,
	output ffsa_pkg::hdr_t     rd_data
);
	import ffsa_pkg::*;

	hdr_t mem [STORE_DEPTH];
	hdr_t rd_q;
	logic w0_written_q;
	logic rd_unset_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_idx];
		end
	end

	// word 0 reads as the reset header until it is first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_written_q <= 1'b0;
			rd_unset_q   <= 1'b0;
		end else begin
			if (req.wr_en && (req.wr_idx == '0)) begin
				w0_written_q <= 1'b1;
			end
			if (req.rd_en) begin
				rd_unset_q <= (req.rd_idx == '0) && !w0_written_q;
			end
		end
	end

	assign rd_data = rd_unset_q ? HDR_RESET : rd_q;
endmodule

/* rtl/ffsa_walker.sv */
// Chain walker: follows the header chain, splits, marks and merges blocks, holds the response.
module ffsa_walker (
	input  logic               clk,
	input  logic               arst_n,
	ffsa_req_if.sink           req,
	ffsa_rsp_if.source         rsp,
	output ffsa_pkg::mem_req_t mem_req,
	input  ffsa_pkg::hdr_t     rd_data
);
	import ffsa_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_WR_SPLIT,
		S_WR_USED,
		S_MERGE,
		S_WR_FREE,
		S_RESULT
	} state_t;

	state_t            state_q;
	logic              op_q;
	logic [REQ_W-1:0]  req_size_q;
	logic [OFFS_W-1:0] target_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  last_pos_q;
	logic [POS_W-1:0]  cur_pos_q;
	hdr_t              last_hdr_q;
	logic              have_last_q;
	logic [SIZE_W-1:0] cur_size_q;
	idx_t              split_idx_q;
	logic [SIZE_W-1:0] split_size_q;
	status_t           res_status_q;
	logic [OFFS_W-1:0] res_offset_q;
	logic              out_valid_q;
	status_t           out_status_q;
	logic [OFFS_W-1:0] out_offset_q;

	logic [REQ_W-1:0]  req_round;
	logic [31:0]       size_w;
	logic [31:0]       pos_plus;
	logic [31:0]       nxt_pos;
	logic [31:0]       split_pos;
	logic [31:0]       merged_size;
	logic [31:0]       final_size;
	logic              at_end;
	logic              fits;
	logic              split;
	logic              match;
	logic              merge_last;
	logic              hit;

	assign req_round   = (REQ_W'(req.alloc_size) + REQ_W'(3)) & ~REQ_W'(3);
	assign size_w      = 32'(rd_data.size);
	assign pos_plus    = 32'(pos_q) + 32'(HDR_BYTES);
	assign nxt_pos     = pos_plus + size_w;
	assign split_pos   = pos_plus + 32'(req_size_q);
	assign at_end      = nxt_pos >= 32'(POOL_END);
	assign fits        = rd_data.is_free && (size_w >= 32'(req_size_q));
	assign split       = size_w > (32'(req_size_q) + 32'(HDR_BYTES));
	assign match       = pos_plus == 32'(target_q);
	assign merge_last  = have_last_q && last_hdr_q.is_free;
	assign merged_size = merge_last ? (32'(last_hdr_q.size) + size_w + 32'(HDR_BYTES)) : size_w;
	assign final_size  = rd_data.is_free
		? (32'(cur_size_q) + size_w + 32'(HDR_BYTES)) : 32'(cur_size_q);
	assign hit         = (op_q == OP_ALLOC) ? fits : match;

	always_comb begin
		mem_req = '0;
		unique case (state_q)
			S_IDLE: begin
				mem_req.rd_en = req.valid;
			end
			S_WALK: begin
				// on a free match the successor is read for the merge
				mem_req.rd_en  = !at_end && !((op_q == OP_ALLOC) && fits);
				mem_req.rd_idx = nxt_pos[IDX_W+1:2];
			end
			S_WR_SPLIT: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_idx  = split_idx_q;
				mem_req.wr_data = '{is_free: 1'b1, size: split_size_q};
			end
			S_WR_USED: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_idx  = pos_q[POS_W-1:2];
				mem_req.wr_data = '{is_free: 1'b0, size: cur_size_q};
			end
			S_MERGE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_idx  = cur_pos_q[POS_W-1:2];
				mem_req.wr_data = '{is_free: 1'b1, size: final_size[SIZE_W-1:0]};
			end
			S_WR_FREE: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_idx  = cur_pos_q[POS_W-1:2];
				mem_req.wr_data = '{is_free: 1'b1, size: cur_size_q};
			end
			S_RESULT: begin
				mem_req = '0;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_ALLOC;
			req_size_q   <= '0;
			target_q     <= '0;
			pos_q        <= '0;
			last_pos_q   <= '0;
			cur_pos_q    <= '0;
			last_hdr_q   <= '0;
			have_last_q  <= 1'b0;
			cur_size_q   <= '0;
			split_idx_q  <= '0;
			split_size_q <= '0;
			res_status_q <= ST_NO_SPACE;
			res_offset_q <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_NO_SPACE;
			out_offset_q <= '0;
		end else begin
			if (rsp.ready && (state_q != S_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q        <= req.op;
						req_size_q  <= req_round;
						target_q    <= req.free_offset;
						pos_q       <= '0;
						have_last_q <= 1'b0;
						state_q     <= S_WALK;
					end
				end
				S_WALK: begin
					if (hit && (op_q == OP_ALLOC)) begin
						res_status_q <= ST_ALLOCATED;
						res_offset_q <= pos_plus[OFFS_W-1:0];
						if (split) begin
							split_idx_q  <= split_pos[IDX_W+1:2];
							split_size_q <= SIZE_W'(size_w - 32'(req_size_q) - 32'(HDR_BYTES));
							cur_size_q   <= SIZE_W'(req_size_q);
							state_q      <= S_WR_SPLIT;
						end else begin
							cur_size_q <= rd_data.size;
							state_q    <= S_WR_USED;
						end
					end else if (hit) begin
						res_status_q <= ST_FREED;
						res_offset_q <= '0;
						cur_pos_q    <= merge_last ? last_pos_q : pos_q;
						cur_size_q   <= merged_size[SIZE_W-1:0];
						state_q      <= at_end ? S_WR_FREE : S_MERGE;
					end else begin
						last_pos_q  <= pos_q;
						last_hdr_q  <= rd_data;
						have_last_q <= 1'b1;
						if (at_end) begin
							res_status_q <= (op_q == OP_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
							res_offset_q <= '0;
							state_q      <= S_RESULT;
						end else begin
							pos_q <= nxt_pos[POS_W-1:0];
						end
					end
				end
				S_WR_SPLIT: begin
					state_q <= S_WR_USED;
				end
				S_WR_USED, S_MERGE, S_WR_FREE: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					// hold until the output register is free
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_offset_q <= res_offset_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.payload_offset = out_offset_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en))
		else $error("header store read and written in the same cycle");

	a_accept_walks: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_WALK))
		else $error("accepted beat did not start a walk");

	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != ST_ALLOCATED)) |-> (out_offset_q == '0))
		else $error("non-zero offset on a beat that is not an allocation");

	a_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_RESULT) && out_valid_q && !rsp.ready)
		|=> ((state_q == S_RESULT) && $stable(out_status_q) && $stable(out_offset_q)))
		else $error("pending response beat overwritten");
endmodule

/* bench/first_fit_scratch_allocator_tb.sv */
// Self-checking testbench of the first-fit scratch allocator with a shadow header chain.
module first_fit_scratch_allocator_tb;
	import ffsa_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned LIVE_CAP    = 48;
	localparam int unsigned STALE_CAP   = 32;
	localparam int unsigned DRAIN_TAIL  = 20;

	typedef struct {
		status_t           status;
		logic [OFFS_W-1:0] offset;
	} outcome_t;

	logic clk;
	logic arst_n;

	ffsa_req_if req_ch ();
	ffsa_rsp_if rsp_ch ();

	first_fit_scratch_allocator u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	hdr_t              hdr_shadow [STORE_DEPTH];
	outcome_t          outcome_q [$];
	logic [OFFS_W-1:0] live_q [$];
	logic [OFFS_W-1:0] stale_q [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned rsp_hold_left;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	function automatic hdr_t shadow_read(input longint unsigned pos);
		if ((pos >> 2) < STORE_DEPTH)
			return hdr_shadow[idx_t'(pos >> 2)];
		return '0;
	endfunction

	function automatic void shadow_write(input longint unsigned pos, input logic is_free,
			input longint unsigned size);
		if ((pos >> 2) < STORE_DEPTH)
			hdr_shadow[idx_t'(pos >> 2)] = '{is_free: is_free, size: SIZE_W'(size)};
	endfunction

	// first free block that holds the rounded size; split off the tail if it exceeds a header
	function automatic outcome_t predict_alloc(input logic [ASIZE_W-1:0] req_size);
		outcome_t          o;
		longint unsigned   want;
		longint unsigned   pos;
		longint unsigned   sz;
		hdr_t              h;
		want     = (64'(req_size) + 64'd3) & ~64'd3;
		pos      = 0;
		o.status = ST_NO_SPACE;
		o.offset = '0;
		while (pos < POOL_END) begin
			h  = shadow_read(pos);
			sz = 64'(h.size);
			if (h.is_free && sz >= want) begin
				if (sz > want + HDR_BYTES) begin
					shadow_write(pos + HDR_BYTES + want, 1'b1, sz - want - HDR_BYTES);
					sz = want;
				end
				shadow_write(pos, 1'b0, sz);
				o.status = ST_ALLOCATED;
				o.offset = OFFS_W'(pos + HDR_BYTES);
				return o;
			end
			pos += HDR_BYTES + sz;
		end
		return o;
	endfunction

	// mark the matching block free, absorbing a free predecessor and a free successor
	function automatic outcome_t predict_free(input logic [OFFS_W-1:0] target);
		outcome_t        o;
		longint unsigned pos;
		longint unsigned last_pos;
		longint unsigned sz;
		longint unsigned cur;
		longint unsigned cur_sz;
		longint unsigned nxt;
		bit              have_last;
		hdr_t            h;
		pos       = 0;
		last_pos  = 0;
		have_last = 1'b0;
		o.status  = ST_NOT_FOUND;
		o.offset  = '0;
		while (pos < POOL_END) begin
			h  = shadow_read(pos);
			sz = 64'(h.size);
			if (pos + HDR_BYTES == 64'(target)) begin
				cur    = pos;
				cur_sz = sz;
				h      = shadow_read(last_pos);
				if (have_last && h.is_free) begin
					cur_sz = 64'(h.size) + sz + HDR_BYTES;
					cur    = last_pos;
				end
				nxt = cur + cur_sz + HDR_BYTES;
				if (nxt < POOL_END) begin
					h = shadow_read(nxt);
					if (h.is_free)
						cur_sz += 64'(h.size) + HDR_BYTES;
				end
				shadow_write(cur, 1'b1, cur_sz);
				o.status = ST_FREED;
				return o;
			end
			last_pos  = pos;
			have_last = 1'b1;
			pos      += HDR_BYTES + sz;
		end
		return o;
	endfunction

	// offer one request beat; the unused field carries noise
	task automatic send_request(input logic op, input logic [ASIZE_W-1:0] arg,
			output outcome_t predicted);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		if (op == OP_ALLOC) begin
			req_ch.alloc_size  <= arg;
			req_ch.free_offset <= OFFS_W'($urandom);
		end else begin
			req_ch.alloc_size  <= ASIZE_W'($urandom_range(0, 65536));
			req_ch.free_offset <= arg[OFFS_W-1:0];
		end
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (op == OP_ALLOC)
			predicted = predict_alloc(arg);
		else
			predicted = predict_free(arg[OFFS_W-1:0]);
		outcome_q.push_back(predicted);
	endtask

	task automatic run_random(input int unsigned n_items);
		outcome_t          o;
		int unsigned       r;
		int unsigned       k;
		logic [ASIZE_W-1:0] sz;
		logic [OFFS_W-1:0] off;
		repeat (n_items) begin
			r = $urandom_range(0, 99);
			if (live_q.size() == 0 || (r < 55 && live_q.size() < LIVE_CAP)) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					sz = ASIZE_W'($urandom_range(0, 64));
				else if (r < 90)
					sz = ASIZE_W'($urandom_range(65, 1024));
				else if (r < 98)
					sz = ASIZE_W'($urandom_range(1025, 16384));
				else
					sz = ASIZE_W'($urandom_range(16385, 65536));
				send_request(OP_ALLOC, sz, o);
				if (o.status == ST_ALLOCATED)
					live_q.push_back(o.offset);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 84) begin
					k   = $urandom_range(0, live_q.size() - 1);
					off = live_q[k];
					live_q.delete(k);
					if (stale_q.size() >= STALE_CAP)
						void'(stale_q.pop_front());
					stale_q.push_back(off);
				end else if (r < 92 && stale_q.size() > 0) begin
					// double free, or a reused offset
					off = stale_q[$urandom_range(0, stale_q.size() - 1)];
				end else begin
					off = OFFS_W'($urandom);
				end
				send_request(OP_FREE, ASIZE_W'(off), o);
			end
		end
	endtask

	task automatic test_directed_cases();
		outcome_t o;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_request(OP_ALLOC, 17'd0, o);
		send_request(OP_ALLOC, 17'd1, o);
		send_request(OP_ALLOC, 17'd3, o);
		send_request(OP_ALLOC, 17'd16, o);
		send_request(OP_ALLOC, 17'd13, o);
		send_request(OP_ALLOC, 17'd65536, o);
		send_request(OP_FREE, 17'd0, o);
		send_request(OP_FREE, 17'd6, o);
		send_request(OP_FREE, 17'd65535, o);
		send_request(OP_FREE, 17'd32768, o);
		// exact fit, then a leftover of one header that is not split off
		send_request(OP_FREE, 17'd24, o);
		send_request(OP_ALLOC, 17'd16, o);
		send_request(OP_FREE, 17'd24, o);
		send_request(OP_ALLOC, 17'd12, o);
		send_request(OP_FREE, 17'd24, o);
		send_request(OP_FREE, 17'd16, o);
		send_request(OP_FREE, 17'd16, o);
		send_request(OP_FREE, 17'd44, o);
		send_request(OP_FREE, 17'd8, o);
		send_request(OP_FREE, 17'd4, o);
		send_request(OP_ALLOC, 17'd65532, o);
		send_request(OP_ALLOC, 17'd0, o);
		send_request(OP_FREE, 17'd4, o);
		send_request(OP_ALLOC, 17'd65528, o);
		send_request(OP_FREE, 17'd4, o);
	endtask

	task automatic test_random_no_idling();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		run_random(450);
	endtask

	task automatic test_random_sender_gaps();
		send_idle_pct  = 62;
		recv_stall_pct = 0;
		run_random(450);
	endtask

	task automatic test_random_receiver_stalls();
		send_idle_pct  = 0;
		recv_stall_pct = 62;
		run_random(450);
	endtask

	task automatic test_random_both_idle();
		send_idle_pct  = 32;
		recv_stall_pct = 32;
		run_random(450);
	endtask

	// hold the response side shut while requests keep coming
	task automatic test_output_backpressure();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		rsp_hold_left = 400;
		run_random(120);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (rsp_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_left--;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		outcome_t want_o;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (outcome_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result beat: status %0d offset %0d",
							rsp_ch.status, rsp_ch.payload_offset);
				end else begin
					want_o = outcome_q.pop_front();
					if (rsp_ch.status !== want_o.status ||
							rsp_ch.payload_offset !== want_o.offset) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: expected status %0d offset %0d, got %0d %0d",
								want_o.status, want_o.offset,
								rsp_ch.status, rsp_ch.payload_offset);
					end
				end
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.op          = OP_ALLOC;
		req_ch.alloc_size  = '0;
		req_ch.free_offset = '0;
		rsp_ch.ready       = 1'b0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		rsp_hold_left      = 0;
		mismatch_count     = 0;
		for (int i = 0; i < STORE_DEPTH; i++)
			hdr_shadow[i] = '0;
		hdr_shadow[0] = HDR_RESET;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_no_idling();
		test_random_sender_gaps();
		test_random_receiver_stalls();
		test_random_both_idle();
		test_output_backpressure();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
